### design/txn_weight_fee_check_defines.svh
// assertion macros for the transaction weight and fee checker
// used by the top level; expects i_clk and i_rst_n in scope
`ifndef TXN_WEIGHT_FEE_CHECK_DEFINES_SVH
`define TXN_WEIGHT_FEE_CHECK_DEFINES_SVH

`ifndef ASSERT_OFF
`define TWFC_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("twfc assertion failed");
`define TWFC_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("twfc assertion failed");
`else
`define TWFC_ASSERT(label, prop)
`define TWFC_ASSERT_ALWAYS(label, prop)
`endif

`endif

### design/twfc_pkg.sv
// shared constants, types and control structs of the weight and fee checker
// no dependencies
package twfc_pkg;

    localparam int MAX_RECORDS = 255;

    localparam int AMOUNT_W  = 51;
    localparam int TOTAL_W   = 59;
    localparam int BASE_W    = 18;
    localparam int COUNT_W   = 8;
    localparam int BYTE_W    = 8;
    localparam int WEIGHT_W  = 20;
    localparam int THR_W     = 41;
    localparam int RATE_W    = 32;
    localparam int RATE_Q_W  = 23;
    localparam int MUL_A_W   = RATE_Q_W;
    localparam int MUL_B_W   = WEIGHT_W - 2;
    localparam int MUL_P_W   = THR_W;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [BASE_W-1:0]    INPUT_BYTES   = BASE_W'(41);
    localparam logic [BASE_W-1:0]    OUTPUT_BYTES  = BASE_W'(9);
    localparam logic [BASE_W:0]      FIXED_BYTES   = (BASE_W+1)'(10);
    localparam logic [WEIGHT_W:0]    SEGWIT_HEADER = (WEIGHT_W+1)'(2);
    localparam logic [BYTE_W-1:0]    SIG_SIZE_RESET = BYTE_W'(107);
    localparam logic [AMOUNT_W-1:0]  FEE_MAX       = {AMOUNT_W{1'b1}};

    // rate / 1000 as ((rate >> 3) * ceil(2^36 / 125)) >> 36
    localparam int   RECIP_SHIFT = 36;
    localparam logic [29:0] RECIP_125 = 30'd549755814;

    localparam logic MODE_INPUT  = 1'b0;
    localparam logic MODE_OUTPUT = 1'b1;

    localparam logic REG_MAX_FEE_RATE = 1'b0;
    localparam logic REG_SIG_SIZE     = 1'b1;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SEGLD  = 7'b0000010,
        ST_SEG    = 7'b0000100,
        ST_WEIGHT = 7'b0001000,
        ST_THRLD  = 7'b0010000,
        ST_THR    = 7'b0100000,
        ST_OUT    = 7'b1000000
    } t_state;

    typedef struct packed {
        logic                mode;
        logic [AMOUNT_W-1:0] amount;
        logic [BYTE_W-1:0]   script_first_byte;
        logic [BYTE_W-1:0]   script_length;
    } t_rec;

    typedef struct packed {
        logic [BASE_W-1:0]  base_bytes;
        logic [COUNT_W-1:0] seg_inputs;
        logic [TOTAL_W-1:0] input_total;
        logic [TOTAL_W-1:0] output_total;
        logic               overflow;
    } t_acc;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [MUL_P_W-1:0] product;
    } t_mul_rsp;

    typedef struct packed {
        logic [RATE_Q_W-1:0] rate_q;
        logic [BYTE_W-1:0]   sig_size;
    } t_cfg;

endpackage

### design/twfc_if.sv
// record and result channels of the weight and fee checker
// depends on twfc_pkg
interface twfc_rec_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [twfc_pkg::AMOUNT_W-1:0] amount;
    logic [twfc_pkg::BYTE_W-1:0]   script_first_byte;
    logic [twfc_pkg::BYTE_W-1:0]   script_length;
    logic                          is_last;

    modport source (output valid, mode, amount, script_first_byte, script_length, is_last,
                    input ready);
    modport sink (input valid, mode, amount, script_first_byte, script_length, is_last,
                  output ready);
endinterface

interface twfc_res_if;
    logic                          valid;
    logic                          ready;
    logic [twfc_pkg::WEIGHT_W-1:0] weight;
    logic [twfc_pkg::AMOUNT_W-1:0] fee;
    logic                          overspend;
    logic [twfc_pkg::THR_W-1:0]    fee_threshold;
    logic                          count_overflow;

    modport source (output valid, weight, fee, overspend, fee_threshold, count_overflow,
                    input ready);
    modport sink (input valid, weight, fee, overspend, fee_threshold, count_overflow,
                  output ready);
endinterface

### design/twfc_cfg.sv
// configuration registers on an apb-style port, plus the rate divided by 1000
// depends on twfc_pkg
module twfc_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [twfc_pkg::PADDR_W-1:0] paddr,
    input  logic [twfc_pkg::PDATA_W-1:0] pwdata,
    output logic [twfc_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output twfc_pkg::t_cfg               o_cfg
);
    import twfc_pkg::*;

    logic [RATE_W-1:0]   r_max_fee_rate;
    logic [BYTE_W-1:0]   r_sig_size;
    logic [RATE_Q_W-1:0] r_rate_q;
    logic [RATE_Q_W-1:0] n_rate_q;
    logic [RATE_W-4:0]   w_rate_div8;
    logic [RATE_W-4+30:0] w_prod;
    logic                w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    assign w_rate_div8 = r_max_fee_rate[RATE_W-1:3];
    assign w_prod      = w_rate_div8 * RECIP_125;
    assign n_rate_q    = w_prod[RECIP_SHIFT+RATE_Q_W-1:RECIP_SHIFT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_fee_rate <= '0;
            r_sig_size     <= SIG_SIZE_RESET;
            r_rate_q       <= '0;
        end else begin
            r_rate_q <= n_rate_q;
            if (w_wr) begin
                unique case (paddr[2])
                    REG_MAX_FEE_RATE: r_max_fee_rate <= pwdata;
                    REG_SIG_SIZE:     r_sig_size     <= pwdata[BYTE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MAX_FEE_RATE: prdata = r_max_fee_rate;
            REG_SIG_SIZE:     prdata = {{(PDATA_W-BYTE_W){1'b0}}, r_sig_size};
            default:          prdata = '0;
        endcase
    end

    assign o_cfg.rate_q   = r_rate_q;
    assign o_cfg.sig_size = r_sig_size;

endmodule

### design/twfc_acc.sv
// per-transaction accumulators: byte count, segwit count, totals, record counts
// depends on twfc_pkg
module twfc_acc (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic                        i_clear,
    input  twfc_pkg::t_rec              i_rec,
    input  logic [twfc_pkg::BYTE_W-1:0] i_sig_size,
    output twfc_pkg::t_acc              o_acc
);
    import twfc_pkg::*;

    logic [BASE_W-1:0]  r_base_bytes;
    logic [COUNT_W-1:0] r_seg_inputs;
    logic [TOTAL_W-1:0] r_input_total;
    logic [TOTAL_W-1:0] r_output_total;
    logic [COUNT_W-1:0] r_input_records;
    logic [COUNT_W-1:0] r_output_records;
    logic               r_overflow;
    logic               w_in_full;
    logic               w_out_full;
    logic               w_segwit;

    assign w_in_full  = r_input_records >= COUNT_W'(MAX_RECORDS);
    assign w_out_full = r_output_records >= COUNT_W'(MAX_RECORDS);
    assign w_segwit   = i_rec.script_first_byte == '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_base_bytes     <= '0;
            r_seg_inputs     <= '0;
            r_input_total    <= '0;
            r_output_total   <= '0;
            r_input_records  <= '0;
            r_output_records <= '0;
            r_overflow       <= 1'b0;
        end else if (i_accept) begin
            case (i_rec.mode)
                MODE_INPUT: begin
                    if (w_in_full) begin
                        r_overflow <= 1'b1;
                    end else begin
                        r_input_records <= r_input_records + 1'b1;
                        r_input_total   <= r_input_total + TOTAL_W'(i_rec.amount);
                        if (w_segwit) begin
                            r_seg_inputs <= r_seg_inputs + 1'b1;
                            r_base_bytes <= r_base_bytes + INPUT_BYTES;
                        end else begin
                            r_base_bytes <= r_base_bytes + INPUT_BYTES + BASE_W'(i_sig_size);
                        end
                    end
                end
                default: begin
                    if (w_out_full) begin
                        r_overflow <= 1'b1;
                    end else begin
                        r_output_records <= r_output_records + 1'b1;
                        r_output_total   <= r_output_total + TOTAL_W'(i_rec.amount);
                        r_base_bytes     <= r_base_bytes + OUTPUT_BYTES
                                            + BASE_W'(i_rec.script_length);
                    end
                end
            endcase
        end
    end

    assign o_acc.base_bytes   = r_base_bytes;
    assign o_acc.seg_inputs   = r_seg_inputs;
    assign o_acc.input_total  = r_input_total;
    assign o_acc.output_total = r_output_total;
    assign o_acc.overflow     = r_overflow;

endmodule

### design/twfc_mul.sv
// shared shift-add multiplier, one multiplier bit per cycle, stops early
// depends on twfc_pkg
module twfc_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  twfc_pkg::t_mul_req i_req,
    output twfc_pkg::t_mul_rsp o_rsp
);
    import twfc_pkg::*;

    logic               r_busy;
    logic [MUL_P_W-1:0] r_acc;
    logic [MUL_P_W-1:0] r_a;
    logic [MUL_B_W-1:0] r_b;
    logic               w_done;

    assign w_done = r_busy && (r_b == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
        end else if (w_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= '0;
            r_a   <= MUL_P_W'(i_req.a);
            r_b   <= i_req.b;
        end else if (r_busy && !w_done) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= {r_a[MUL_P_W-2:0], 1'b0};
            r_b <= {1'b0, r_b[MUL_B_W-1:1]};
        end
    end

    assign o_rsp.busy    = r_busy;
    assign o_rsp.done    = w_done;
    assign o_rsp.product = r_acc;

endmodule

### design/txn_weight_fee_check.sv
// Transaction weight and fee checker, top level.
// Records arrive on i_rec (valid/ready); each is a spent input or an output.
// A record that is not the last one is accepted and ready stays high.
// The last record of a transaction starts the final pass: ready drops while a
// small sequencer drives one shift-add multiplier twice, first for the
// signature bytes times the segwit count, then for the rate quotient times
// weight/4. The multiplier retires one multiplier bit per cycle and stops when
// the remaining bits are zero. The result sits in an output register on o_res,
// and records of the following transaction are taken while it waits there; if
// the receiver still stalls when the next result is due, the sequencer waits
// before loading it, and no records are taken meanwhile.
// Registers on the apb-style port: 0x0 max_fee_rate, 0x4 script_sig_size.
// Reset (synchronous, active low) clears the accumulators and the output valid
// flag, sets max_fee_rate to 0 and script_sig_size to 107.
// Depends on twfc_pkg, twfc_if, twfc_cfg, twfc_acc, twfc_mul and the defines header.
`include "txn_weight_fee_check_defines.svh"

module txn_weight_fee_check (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    twfc_rec_if.sink                     i_rec,
    twfc_res_if.source                   o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [twfc_pkg::PADDR_W-1:0] paddr,
    input  logic [twfc_pkg::PDATA_W-1:0] pwdata,
    output logic [twfc_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import twfc_pkg::*;

    t_state   r_state;
    t_state   n_state;
    t_cfg     w_cfg;
    t_acc     w_acc;
    t_rec     w_rec;
    t_mul_req w_mul_req;
    t_mul_rsp w_mul_rsp;

    logic                w_accept;
    logic                w_clear;
    logic                w_out_free;
    logic [BASE_W:0]     w_base_fixed;
    logic [WEIGHT_W:0]   w_base4;
    logic [WEIGHT_W:0]   w_seg_term;
    logic [TOTAL_W-1:0]  w_diff;
    logic                w_over;
    logic [AMOUNT_W-1:0] w_fee;

    logic [WEIGHT_W-1:0] r_weight;
    logic [AMOUNT_W-1:0] r_fee;
    logic                r_over;
    logic                r_ovf;

    logic                r_out_valid;
    logic [WEIGHT_W-1:0] r_out_weight;
    logic [AMOUNT_W-1:0] r_out_fee;
    logic                r_out_over;
    logic [THR_W-1:0]    r_out_thr;
    logic                r_out_ovf;

    twfc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign i_rec.ready = (r_state == ST_IDLE);
    assign w_accept    = i_rec.valid && i_rec.ready;
    assign w_clear     = (r_state == ST_WEIGHT);

    assign w_rec.mode              = i_rec.mode;
    assign w_rec.amount            = i_rec.amount;
    assign w_rec.script_first_byte = i_rec.script_first_byte;
    assign w_rec.script_length     = i_rec.script_length;

    twfc_acc u_acc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_clear    (w_clear),
        .i_rec      (w_rec),
        .i_sig_size (w_cfg.sig_size),
        .o_acc      (w_acc)
    );

    always_comb begin
        w_mul_req = '0;
        unique case (r_state)
            ST_SEGLD: begin
                w_mul_req.start = 1'b1;
                w_mul_req.a     = MUL_A_W'(w_cfg.sig_size);
                w_mul_req.b     = MUL_B_W'(w_acc.seg_inputs);
            end
            ST_THRLD: begin
                w_mul_req.start = 1'b1;
                w_mul_req.a     = w_cfg.rate_q;
                w_mul_req.b     = r_weight[WEIGHT_W-1:2];
            end
            default: ;
        endcase
    end

    twfc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_rsp   (w_mul_rsp)
    );

    // weight and fee from the accumulators and the first product
    assign w_base_fixed = (BASE_W+1)'(w_acc.base_bytes) + FIXED_BYTES;
    assign w_base4      = {w_base_fixed[WEIGHT_W-2:0], 2'b00};
    assign w_seg_term   = (w_acc.seg_inputs != '0)
                          ? (WEIGHT_W+1)'(w_mul_rsp.product[15:0]) + SEGWIT_HEADER
                          : '0;
    assign w_diff       = w_acc.input_total - w_acc.output_total;
    assign w_over       = w_acc.input_total < w_acc.output_total;
    assign w_fee        = w_over ? '0
                          : (w_diff[TOTAL_W-1:AMOUNT_W] != '0) ? FEE_MAX
                          : w_diff[AMOUNT_W-1:0];

    assign w_out_free = !r_out_valid || o_res.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (w_accept && i_rec.is_last) n_state = ST_SEGLD;
            ST_SEGLD:  n_state = ST_SEG;
            ST_SEG:    if (w_mul_rsp.done) n_state = ST_WEIGHT;
            ST_WEIGHT: n_state = ST_THRLD;
            ST_THRLD:  n_state = ST_THR;
            ST_THR:    if (w_mul_rsp.done) n_state = ST_OUT;
            ST_OUT:    if (w_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_WEIGHT) begin
            r_weight <= WEIGHT_W'(w_base4 + w_seg_term);
            r_fee    <= w_fee;
            r_over   <= w_over;
            r_ovf    <= w_acc.overflow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_OUT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_OUT) && w_out_free) begin
            r_out_weight <= r_weight;
            r_out_fee    <= r_fee;
            r_out_over   <= r_over;
            r_out_thr    <= w_mul_rsp.product;
            r_out_ovf    <= r_ovf;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.weight         = r_out_weight;
    assign o_res.fee            = r_out_fee;
    assign o_res.overspend      = r_out_over;
    assign o_res.fee_threshold  = r_out_thr;
    assign o_res.count_overflow = r_out_ovf;

    `TWFC_ASSERT(a_last_starts_final, (w_accept && i_rec.is_last) |=> (r_state == ST_SEGLD))
    `TWFC_ASSERT(a_valid_from_out, $rose(o_res.valid) |-> ($past(r_state) == ST_OUT))
    `TWFC_ASSERT(a_mul_idle_at_out, (r_state == ST_OUT) |-> !w_mul_rsp.busy)
    `TWFC_ASSERT(a_overspend_fee_zero, (o_res.valid && o_res.overspend) |-> (o_res.fee == '0))
    `TWFC_ASSERT_ALWAYS(a_no_accept_in_reset, !i_rst_n |=> !o_res.valid)

endmodule

### dv/testbench.sv
// self-checking testbench for txn_weight_fee_check: streams transaction records,
// predicts the weight, fee and threshold of each transaction and checks every result
// depends on twfc_pkg, twfc_if and the txn_weight_fee_check rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import twfc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 25;

    localparam logic [PADDR_W-1:0] ADDR_MAX_FEE_RATE = PADDR_W'(0);
    localparam logic [PADDR_W-1:0] ADDR_SIG_SIZE     = PADDR_W'(4);

    localparam logic [63:0] TX_FIXED_BYTES  = 64'd10;
    localparam logic [63:0] TX_INPUT_BYTES  = 64'd41;
    localparam logic [63:0] TX_OUTPUT_BYTES = 64'd9;
    localparam logic [63:0] TX_SEGWIT_HDR   = 64'd2;
    localparam logic [63:0] TX_RATE_DIV     = 64'd1000;
    localparam logic [50:0] AMOUNT_MAX      = {51{1'b1}};

    typedef struct {
        logic [WEIGHT_W-1:0] weight;
        logic [AMOUNT_W-1:0] fee;
        logic                overspend;
        logic [THR_W-1:0]    fee_threshold;
        logic                count_overflow;
    } t_fee_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    twfc_rec_if rec_ch ();
    twfc_res_if res_ch ();

    txn_weight_fee_check uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rec   (rec_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    logic [31:0]         rate_cfg;
    logic [BYTE_W-1:0]   sig_cfg;
    logic [BASE_W-1:0]   acc_base;
    logic [COUNT_W-1:0]  acc_segwit;
    logic [TOTAL_W-1:0]  acc_in_total;
    logic [TOTAL_W-1:0]  acc_out_total;
    logic [COUNT_W-1:0]  acc_in_recs;
    logic [COUNT_W-1:0]  acc_out_recs;
    logic                acc_overflow;

    t_fee_result fee_reports_due[$];

    int fail_count;
    int records_sent;
    int reports_checked;
    int overflow_reports;
    int config_writes;
    int cycle_count;
    int sender_idle_pct;
    int recv_stall_pct;
    int hold_left;
    bit hold_req;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t timeout with %0d results outstanding", $time, fee_reports_due.size());
            $display("txn_weight_fee_check verification failed");
            $finish;
        end
    end

    // receiver side, random stalls plus a long hold-off on request
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t mismatch on %s: expected %h actual %h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_fee_result exp_r;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (fee_reports_due.size() == 0) begin
                $display("%0t unexpected result: expected none actual weight %h fee %h",
                         $time, res_ch.weight, res_ch.fee);
                fail_count++;
            end else begin
                exp_r = fee_reports_due.pop_front();
                check_field("weight", 64'(exp_r.weight), 64'(res_ch.weight));
                check_field("fee", 64'(exp_r.fee), 64'(res_ch.fee));
                check_field("overspend", 64'(exp_r.overspend), 64'(res_ch.overspend));
                check_field("fee_threshold", 64'(exp_r.fee_threshold),
                            64'(res_ch.fee_threshold));
                check_field("count_overflow", 64'(exp_r.count_overflow),
                            64'(res_ch.count_overflow));
                reports_checked++;
                if (exp_r.count_overflow)
                    overflow_reports++;
            end
        end
    end

    function automatic void clear_txn_state();
        acc_base = '0;
        acc_segwit = '0;
        acc_in_total = '0;
        acc_out_total = '0;
        acc_in_recs = '0;
        acc_out_recs = '0;
        acc_overflow = 1'b0;
    endfunction

    function automatic void accumulate_record(logic mode, logic [AMOUNT_W-1:0] amount,
                                              logic [BYTE_W-1:0] first, logic [BYTE_W-1:0] slen,
                                              logic last);
        logic [63:0] wt;
        logic [63:0] diff;
        t_fee_result r;
        if (mode == MODE_INPUT) begin
            if (acc_in_recs >= COUNT_W'(MAX_RECORDS)) begin
                acc_overflow = 1'b1;
            end else begin
                acc_in_recs = acc_in_recs + 1'b1;
                acc_in_total = acc_in_total + TOTAL_W'(amount);
                if (first == 8'd0) begin
                    acc_segwit = acc_segwit + 1'b1;
                    acc_base = BASE_W'(64'(acc_base) + TX_INPUT_BYTES);
                end else begin
                    acc_base = BASE_W'(64'(acc_base) + TX_INPUT_BYTES + 64'(sig_cfg));
                end
            end
        end else begin
            if (acc_out_recs >= COUNT_W'(MAX_RECORDS)) begin
                acc_overflow = 1'b1;
            end else begin
                acc_out_recs = acc_out_recs + 1'b1;
                acc_out_total = acc_out_total + TOTAL_W'(amount);
                acc_base = BASE_W'(64'(acc_base) + TX_OUTPUT_BYTES + 64'(slen));
            end
        end
        if (last) begin
            wt = 64'd4 * (64'(acc_base) + TX_FIXED_BYTES);
            if (acc_segwit != '0)
                wt = wt + TX_SEGWIT_HDR + 64'(sig_cfg) * 64'(acc_segwit);
            r.weight = wt[WEIGHT_W-1:0];
            if (acc_in_total < acc_out_total) begin
                r.fee = '0;
                r.overspend = 1'b1;
            end else begin
                diff = 64'(acc_in_total - acc_out_total);
                r.fee = (diff > 64'(AMOUNT_MAX)) ? AMOUNT_MAX : diff[AMOUNT_W-1:0];
                r.overspend = 1'b0;
            end
            r.fee_threshold = THR_W'((64'(rate_cfg) / TX_RATE_DIV) * (64'(r.weight) / 64'd4));
            r.count_overflow = acc_overflow;
            fee_reports_due.push_back(r);
            clear_txn_state();
        end
    endfunction

    task automatic send_record(logic mode, logic [AMOUNT_W-1:0] amount, logic [BYTE_W-1:0] first,
                               logic [BYTE_W-1:0] slen, logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            rec_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        rec_ch.valid <= 1'b1;
        rec_ch.mode <= mode;
        rec_ch.amount <= amount;
        rec_ch.script_first_byte <= first;
        rec_ch.script_length <= slen;
        rec_ch.is_last <= last;
        do @(posedge i_clk); while (!rec_ch.ready);
        accumulate_record(mode, amount, first, slen, last);
        records_sent++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        rec_ch.valid <= 1'b0;
        while (fee_reports_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_MAX_FEE_RATE)
            rate_cfg = data;
        else if (addr == ADDR_SIG_SIZE)
            sig_cfg = data[BYTE_W-1:0];
        config_writes++;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_config(logic [31:0] rate, logic [BYTE_W-1:0] sig);
        wait_idle();
        apb_write(ADDR_MAX_FEE_RATE, rate);
        apb_write(ADDR_SIG_SIZE, PDATA_W'(sig));
    endtask

    function automatic logic [AMOUNT_W-1:0] rand_amount();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(9))
            0: return '0;
            1: return AMOUNT_MAX;
            2, 3: return AMOUNT_W'($urandom_range(100000));
            default: return r[AMOUNT_W-1:0];
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] rand_first();
        return ($urandom_range(99) < 40) ? 8'd0 : BYTE_W'($urandom);
    endfunction

    task automatic send_random_txn(int len);
        for (int i = 0; i < len; i++)
            send_record(logic'($urandom_range(1)), rand_amount(), rand_first(),
                        BYTE_W'($urandom), i == len - 1);
    endtask

    function automatic logic [31:0] rand_rate();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'd999;
            3: return 32'd1000;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        // reset values of the registers are in effect here
        send_record(MODE_INPUT, '0, 8'h00, 8'h00, 1'b1);
        send_record(MODE_OUTPUT, AMOUNT_MAX, 8'hFF, 8'hFF, 1'b1);
        send_record(MODE_INPUT, AMOUNT_MAX, 8'hFF, 8'h00, 1'b0);
        send_record(MODE_INPUT, AMOUNT_MAX, 8'h01, 8'hFF, 1'b0);
        send_record(MODE_OUTPUT, '0, 8'h00, 8'h00, 1'b1);
        send_record(MODE_INPUT, AMOUNT_W'(1), 8'h80, 8'hFF, 1'b0);
        send_record(MODE_OUTPUT, AMOUNT_W'(1), 8'hFF, 8'hAA, 1'b1);
        send_record(MODE_INPUT, AMOUNT_W'(5000), 8'h00, 8'h55, 1'b0);
        send_record(MODE_INPUT, AMOUNT_W'(7000), 8'h00, 8'h00, 1'b0);
        send_record(MODE_INPUT, AMOUNT_W'(9000), 8'h00, 8'hFF, 1'b0);
        send_record(MODE_OUTPUT, AMOUNT_W'(12000), 8'h00, 8'd25, 1'b1);
        set_config(32'hFFFF_FFFF, 8'd255);
        send_record(MODE_INPUT, AMOUNT_MAX, 8'h00, 8'h00, 1'b0);
        send_record(MODE_INPUT, AMOUNT_W'(3), 8'hFF, 8'h00, 1'b0);
        send_record(MODE_OUTPUT, AMOUNT_W'(2), 8'h00, 8'hFF, 1'b1);
        set_config(32'd999, 8'd0);
        send_record(MODE_INPUT, AMOUNT_W'(100), 8'h00, 8'h00, 1'b0);
        send_record(MODE_OUTPUT, AMOUNT_W'(40), 8'h00, 8'd22, 1'b1);
        set_config(32'd1000, 8'd1);
        send_record(MODE_INPUT, AMOUNT_W'(100), 8'hAB, 8'h00, 1'b0);
        send_record(MODE_INPUT, AMOUNT_W'(100), 8'h00, 8'h00, 1'b0);
        send_record(MODE_OUTPUT, AMOUNT_W'(150), 8'h00, 8'd34, 1'b1);
    endtask

    task automatic test_record_limit();
        set_config(32'hFFFF_FFFF, 8'd255);
        sender_idle_pct = 10;
        recv_stall_pct = 10;
        // the input past the limit carries is_last and is itself ignored
        for (int i = 0; i <= MAX_RECORDS; i++)
            send_record(MODE_INPUT, rand_amount(), rand_first(), BYTE_W'($urandom),
                        i == MAX_RECORDS);
        send_record(MODE_INPUT, rand_amount(), 8'h00, 8'h00, 1'b0);
        for (int i = 0; i < MAX_RECORDS + 2; i++)
            send_record(MODE_OUTPUT, AMOUNT_W'($urandom_range(5000)), rand_first(),
                        BYTE_W'($urandom), i == MAX_RECORDS + 1);
        // overflow flag must clear for the next transaction
        send_random_txn(3);
    endtask

    task automatic test_random_phases();
        int phase_items;
        for (int phase = 0; phase < 4; phase++) begin
            set_config(rand_rate(), ($urandom_range(3) == 0) ? 8'd255 : BYTE_W'($urandom));
            case (phase)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin sender_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                int len;
                len = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
                send_random_txn(len);
                phase_items += len;
            end
        end
    endtask

    task automatic test_backpressure();
        set_config(rand_rate(), BYTE_W'($urandom));
        sender_idle_pct = 0;
        recv_stall_pct = 20;
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++)
            send_random_txn($urandom_range(1, 3));
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rec_ch.valid = 1'b0;
        rec_ch.mode = 1'b0;
        rec_ch.amount = '0;
        rec_ch.script_first_byte = '0;
        rec_ch.script_length = '0;
        rec_ch.is_last = 1'b0;
        rate_cfg = 32'd0;
        sig_cfg = 8'd107;
        clear_txn_state();
        fail_count = 0;
        records_sent = 0;
        reports_checked = 0;
        overflow_reports = 0;
        config_writes = 0;
        cycle_count = 0;
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 0;
        hold_req = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_record_limit();
        test_random_phases();
        test_backpressure();
        wait_idle();

        $display("covered %0d records in %0d checked transactions (%0d over the record limit)",
                 records_sent, reports_checked, overflow_reports);
        $display("with %0d register writes, idle and stall phases and a long receiver hold-off",
                 config_writes);
        if (fail_count == 0)
            $display("txn_weight_fee_check verification clean");
        else
            $display("txn_weight_fee_check verification failed");
        $finish;
    end
endmodule
